[hdl/pfc_pkg.sv]
// Shared types, constants and the control store of the prime filter copy unit.
// Used by pfc_divider and prime_filter_copy_unit; depends on nothing.
`default_nettype none

package pfc_pkg;

  // Fixed field widths of the streams
  localparam int VALUE_W    = 16;
  localparam int IDX_W      = 8;
  localparam int RADIX_BITS = 4;    // quotient bits retired per divider cycle

  // Microprogram addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_EMIT      = 4'd0;
  localparam logic [UPC_W-1:0] UPC_IDLE      = 4'd1;
  localparam logic [UPC_W-1:0] UPC_SCREEN    = 4'd2;
  localparam logic [UPC_W-1:0] UPC_BOUND     = 4'd3;
  localparam logic [UPC_W-1:0] UPC_DIV_RUN   = 4'd4;
  localparam logic [UPC_W-1:0] UPC_CHECK     = 4'd5;
  localparam logic [UPC_W-1:0] UPC_COMPOSITE = 4'd6;
  localparam logic [UPC_W-1:0] UPC_PRIME     = 4'd7;

  // Jump conditions: jump to target when true, otherwise fall through
  typedef enum logic [2:0] {
    COND_NONE        = 3'd0,
    COND_ALWAYS      = 3'd1,
    COND_NO_INPUT    = 3'd2,
    COND_SMALL       = 3'd3,
    COND_SQ_GT       = 3'd4,
    COND_DIV_BUSY    = 3'd5,
    COND_REM_NONZERO = 3'd6,
    COND_OUT_BUSY    = 3'd7
  } cond_t;

  // One control word
  typedef struct packed {
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             in_ready;     // take an input transaction
    logic             div_init;     // load divider
    logic             div_step;     // run one divider cycle
    logic             next_div;     // advance trial divisor and its square
    logic             set_verdict;  // record verdict
    logic             verdict_val;
    logic             emit;         // load output register when free
  } uc_word_t;

  // Divider control and status
  typedef struct packed {
    logic init;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic last_step;
    logic rem_zero;
  } div_status_t;

  localparam uc_word_t UC_NOP = '{cond: COND_NONE, target: UPC_IDLE, default: 1'b0};

  // Control store
  function automatic uc_word_t uc_rom(input logic [UPC_W-1:0] addr);
    uc_word_t w;
    w = UC_NOP;
    case (addr)
      UPC_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = UPC_EMIT;
      end
      UPC_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = COND_NO_INPUT;
        w.target   = UPC_IDLE;
      end
      UPC_SCREEN: begin
        w.cond   = COND_SMALL;
        w.target = UPC_COMPOSITE;
      end
      UPC_BOUND: begin
        w.div_init = 1'b1;
        w.cond     = COND_SQ_GT;
        w.target   = UPC_PRIME;
      end
      UPC_DIV_RUN: begin
        w.div_step = 1'b1;
        w.cond     = COND_DIV_BUSY;
        w.target   = UPC_DIV_RUN;
      end
      UPC_CHECK: begin
        w.next_div = 1'b1;
        w.cond     = COND_REM_NONZERO;
        w.target   = UPC_BOUND;
      end
      UPC_COMPOSITE: begin
        w.set_verdict = 1'b1;
        w.verdict_val = 1'b0;
        w.cond        = COND_ALWAYS;
        w.target      = UPC_EMIT;
      end
      UPC_PRIME: begin
        w.set_verdict = 1'b1;
        w.verdict_val = 1'b1;
        w.cond        = COND_ALWAYS;
        w.target      = UPC_EMIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/pfc_divider.sv]
// Multi-cycle restoring remainder unit, RADIX_BITS quotient bits per cycle with step asserted.
// Depends on pfc_pkg (div_ctrl_t, div_status_t, RADIX_BITS).
`default_nettype none

module pfc_divider #(
  parameter int DATA_W = 16,
  parameter int DIV_W  = 10
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire pfc_pkg::div_ctrl_t  ctrl,
  input  wire logic [DATA_W-1:0]   dividend,
  input  wire logic [DIV_W-1:0]    divisor,
  output pfc_pkg::div_status_t     status
);

  localparam int DIV_CYCLES = (DATA_W + pfc_pkg::RADIX_BITS - 1) / pfc_pkg::RADIX_BITS;
  localparam int PAD_W      = DIV_CYCLES * pfc_pkg::RADIX_BITS;
  localparam int CNT_W      = $clog2(DIV_CYCLES + 1);

  logic [PAD_W-1:0] dsh, dsh_next;
  logic [DIV_W-1:0] rem, rem_next;
  logic [CNT_W-1:0] count;

  // RADIX_BITS restoring steps on the narrow remainder
  always_comb begin
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] r;
    logic [PAD_W-1:0] s;
    r = rem;
    s = dsh;
    t = '0;
    for (int i = 0; i < pfc_pkg::RADIX_BITS; i++) begin
      t = {r, s[PAD_W-1]};
      s = s << 1;
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[DIV_W-1:0];
    end
    rem_next = r;
    dsh_next = s;
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.init) begin
      count <= '0;
    end else if (ctrl.step) begin
      count <= count + CNT_W'(1);
    end
  end

  // Remainder and dividend shift register
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      rem <= '0;
      dsh <= PAD_W'(dividend);
    end else if (ctrl.step) begin
      rem <= rem_next;
      dsh <= dsh_next;
    end
  end

  assign status.last_step = (count == CNT_W'(DIV_CYCLES - 1));
  assign status.rem_zero  = (rem == '0);

endmodule

`default_nettype wire

[hdl/prime_filter_copy_unit.sv]
// Top level of the prime filter copy unit: microcoded trial-division sequencer,
// output register and per-array prime counter. Depends on pfc_pkg, pfc_divider.
//
// Usage:
//   Input stream s_*: one transaction per value; s_tdata[15:0] is the value,
//   s_tlast marks the last value of an array. Output stream m_*: one
//   transaction per input; m_tuser is the prime flag, m_tdata holds
//   prime_value, dest_index and prime_count, m_tlast copies s_tlast.
//   Trial divisors are 2, then odd numbers while divisor squared <= value.
//   Each divisor passes a bound check, a remainder computed 4 bits per
//   divider step, and a remainder check. Values 0 and 1 go straight to a
//   composite verdict; any other value is prime once a divisor's square
//   exceeds it, composite at the first divisor that leaves no remainder.
//   One item is in work at a time; the next input can be taken in the
//   cycle after the result enters the output register, even while that
//   result still waits.
//   Reset (rst, synchronous) clears the prime count, the sequencer and
//   m_tvalid. A stalled receiver holds the result in the output register;
//   the sequencer waits in its emit step until that register frees up.
`default_nettype none

module prime_filter_copy_unit #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_LEN    = 255
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [15:0] value
  input  wire         s_tlast,   // last_item
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [15:0] prime_value, [23:16] dest_index, [31:24] prime_count
  output logic        m_tuser,   // is_prime
  output logic        m_tlast    // last_out
);

  localparam int DW        = (VALUE_BITS < pfc_pkg::VALUE_W) ? VALUE_BITS : pfc_pkg::VALUE_W;
  localparam int DDW       = DW / 2 + 2;
  localparam int SQW       = DW + 2;
  localparam int COUNT_MAX = (MAX_LEN < 255) ? MAX_LEN : 255;
  localparam logic [pfc_pkg::IDX_W-1:0] CNT_LIMIT = pfc_pkg::IDX_W'(COUNT_MAX);

  logic [pfc_pkg::UPC_W-1:0] upc, upc_next;
  pfc_pkg::uc_word_t         uw;
  logic                      take;

  logic [DW-1:0]  value;
  logic           last;
  logic [DDW-1:0] divisor;
  logic [SQW-1:0] square;
  logic           verdict;

  logic [pfc_pkg::IDX_W-1:0] count, count_inc, count_next;
  logic                      in_fire, out_busy, out_load;

  pfc_pkg::div_ctrl_t   dctrl;
  pfc_pkg::div_status_t dstat;

  // Control store fetch; no input is taken while in reset
  assign uw       = pfc_pkg::uc_rom(upc);
  assign s_tready = uw.in_ready & ~rst;
  assign in_fire  = s_tvalid & s_tready;
  assign out_busy = m_tvalid & ~m_tready;
  assign out_load = uw.emit & ~out_busy;

  // Condition select and jump
  always_comb begin
    case (uw.cond)
      pfc_pkg::COND_NONE:        take = 1'b0;
      pfc_pkg::COND_ALWAYS:      take = 1'b1;
      pfc_pkg::COND_NO_INPUT:    take = ~in_fire;
      pfc_pkg::COND_SMALL:       take = (value <= DW'(1));
      pfc_pkg::COND_SQ_GT:       take = (square > SQW'(value));
      pfc_pkg::COND_DIV_BUSY:    take = ~dstat.last_step;
      pfc_pkg::COND_REM_NONZERO: take = ~dstat.rem_zero;
      pfc_pkg::COND_OUT_BUSY:    take = out_busy;
      default:                   take = 1'b0;
    endcase
    upc_next = take ? uw.target : upc + pfc_pkg::UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= pfc_pkg::UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // Operand capture and trial divisor advance: 2, 3, 5, 7, ...
  always_ff @(posedge clk) begin
    if (in_fire) begin
      value   <= s_tdata[DW-1:0];
      last    <= s_tlast;
      divisor <= DDW'(2);
      square  <= SQW'(4);
    end else if (uw.next_div) begin
      if (divisor == DDW'(2)) begin
        divisor <= DDW'(3);
        square  <= SQW'(9);
      end else begin
        divisor <= divisor + DDW'(2);
        square  <= square + SQW'({divisor, 2'b00}) + SQW'(4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uw.set_verdict) begin
      verdict <= uw.verdict_val;
    end
  end

  // Remainder unit
  assign dctrl.init = uw.div_init;
  assign dctrl.step = uw.div_step;

  pfc_divider #(
    .DATA_W (DW),
    .DIV_W  (DDW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (dctrl),
    .dividend (value),
    .divisor  (divisor),
    .status   (dstat)
  );

  // Saturating per-array prime count
  assign count_inc  = (verdict && count < CNT_LIMIT) ? count + pfc_pkg::IDX_W'(1) : count;
  assign count_next = last ? '0 : count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (out_load) begin
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser        <= verdict;
      m_tlast        <= last;
      m_tdata[15:0]  <= verdict ? pfc_pkg::VALUE_W'(value) : '0;
      m_tdata[23:16] <= verdict ? count : '0;
      m_tdata[31:24] <= count_inc;
    end
  end

endmodule

`default_nettype wire
